@@ rtl/core/spod_pkg.sv @@
// Shared constants and types for the spiral ordered dither block.
package spod_pkg;

  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned SIZE_W      = 5;
  localparam int unsigned GRAY_SHIFT  = 8;
  localparam int unsigned RANK_SHIFT  = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd4;

  localparam logic KIND_BUILD = 1'b1;

  localparam logic [COLOR_W-1:0] COEF_R = 8'd77;
  localparam logic [COLOR_W-1:0] COEF_G = 8'd150;
  localparam logic [COLOR_W-1:0] COEF_B = 8'd29;

  localparam logic [COLOR_W-1:0] LEVEL_WHITE = 8'd255;
  localparam logic [COLOR_W-1:0] LEVEL_BLACK = 8'd0;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [SIZE_W-1:0]  size_t;

endpackage

@@ rtl/core/spiral_ordered_dither.sv @@
// Top level of the spiral ordered dither block.
//
// Input channel (in_*): one transaction is a pixel (in_kind 0) or a table
// build command (in_kind 1). A pixel gives one result on out_*: out_level
// 255 when its luma beats the rank at its tile position, else 0. A build
// gives no result; it clears the rank memory and refills it along a spiral.
// Config channel (cfg_*): writes the tile edge length, always ready; write
// it only while the block is idle. Edge 0 acts as 1, above MAX_SIZE clamps.
// Pixels: queue, rank memory read, threshold multiply and compare stages to
// out_valid; one per cycle sustained when out_ready holds and no build runs.
// Build: one sweep of the rank memory (one entry per cycle over a
// 2^clog2(MAX_SIZE) by 2^clog2(MAX_SIZE) array), then the seed cell,
// then the spiral walk; pixels behind it wait in the queue.
// Reset: the same memory sweep runs first; in_ready stays low until it
// ends. Phases go to zero, the edge length to 4.
// A stalled receiver holds out_level; the pipeline freezes, and the
// two-entry queue keeps taking input until it is full.
module spiral_ordered_dither #(
  parameter int unsigned MAX_SIZE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  spod_pkg::color_t      in_red,
  input  spod_pkg::color_t      in_green,
  input  spod_pkg::color_t      in_blue,
  input  logic                  in_end_of_line,
  output logic                  out_valid,
  input  logic                  out_ready,
  output spod_pkg::color_t      out_level,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  spod_pkg::size_t       cfg_dither_size
);

  import spod_pkg::*;

  localparam int unsigned PH_W = $clog2(MAX_SIZE);
  localparam int unsigned N_W  = $clog2(MAX_SIZE + 1);
  localparam int unsigned RK_W = $clog2(MAX_SIZE * MAX_SIZE + 2);
  localparam int unsigned QW   = 2 * PH_W + COLOR_W + 1;

  size_t           size_r;
  logic [N_W-1:0]  n;
  logic [RK_W-1:0] nsq_r;
  logic            init_busy;
  logic            q_in_valid;
  logic            q_in_ready;
  logic [QW-1:0]   q_in_data;
  logic            q_out_valid;
  logic            q_out_ready;
  logic [QW-1:0]   q_out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_dither_size;
    end
  end

  always_comb begin
    if (size_r == '0) begin
      n = N_W'(1);
    end else if (32'(size_r) > 32'(MAX_SIZE)) begin
      n = N_W'(MAX_SIZE);
    end else begin
      n = N_W'(size_r);
    end
  end

  always_ff @(posedge clk) begin
    nsq_r <= RK_W'(RK_W'(n) * RK_W'(n));
  end

  spod_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_end_of_line (in_end_of_line),
    .n              (n),
    .init_busy      (init_busy),
    .q_valid        (q_in_valid),
    .q_ready        (q_in_ready),
    .q_data         (q_in_data)
  );

  spod_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in_data),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_data   (q_out_data)
  );

  spod_back #(
    .MAX_SIZE (MAX_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .n         (n),
    .nsq       (nsq_r),
    .init_busy (init_busy),
    .q_valid   (q_out_valid),
    .q_ready   (q_out_ready),
    .q_data    (q_out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_level (out_level)
  );

endmodule

@@ rtl/core/spod_queue.sv @@
// Small FIFO between the front end and the back end.
module spod_queue #(
  parameter int unsigned W     = 18,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/spod_front.sv @@
// Front end: accepts items, forms gray, tracks the tile phases.
module spod_front #(
  parameter int unsigned MAX_SIZE = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_kind,
  input  spod_pkg::color_t                       in_red,
  input  spod_pkg::color_t                       in_green,
  input  spod_pkg::color_t                       in_blue,
  input  logic                                   in_end_of_line,
  input  logic [$clog2(MAX_SIZE+1)-1:0]          n,
  input  logic                                   init_busy,
  output logic                                   q_valid,
  input  logic                                   q_ready,
  output logic [2*$clog2(MAX_SIZE)+8:0]          q_data
);

  import spod_pkg::*;

  localparam int unsigned PH_W = $clog2(MAX_SIZE);
  localparam int unsigned N_W  = $clog2(MAX_SIZE + 1);
  localparam int unsigned WS_W = 2 * COLOR_W;

  logic [PH_W-1:0] col_ph_r;
  logic [PH_W-1:0] row_ph_r;
  logic [PH_W-1:0] col_ph_nxt;
  logic [PH_W-1:0] row_ph_nxt;
  logic [WS_W-1:0] wsum;
  color_t          gray;
  logic            accept;
  logic            col_wrap;
  logic            row_wrap;

  assign in_ready = q_ready && !init_busy;
  assign q_valid  = in_valid && !init_busy;
  assign accept   = in_valid && in_ready;

  assign wsum = WS_W'(COEF_R) * WS_W'(in_red)
              + WS_W'(COEF_G) * WS_W'(in_green)
              + WS_W'(COEF_B) * WS_W'(in_blue);
  assign gray = wsum[WS_W-1:GRAY_SHIFT];

  assign q_data = {in_kind, gray, col_ph_r, row_ph_r};

  assign col_wrap = ((N_W+1)'(col_ph_r) + (N_W+1)'(1)) >= (N_W+1)'(n);
  assign row_wrap = ((N_W+1)'(row_ph_r) + (N_W+1)'(1)) >= (N_W+1)'(n);

  always_comb begin
    col_ph_nxt = col_ph_r;
    row_ph_nxt = row_ph_r;
    if (accept) begin
      if (in_kind == KIND_BUILD) begin
        col_ph_nxt = '0;
        row_ph_nxt = '0;
      end else if (in_end_of_line) begin
        col_ph_nxt = '0;
        row_ph_nxt = row_wrap ? '0 : row_ph_r + PH_W'(1);
      end else begin
        col_ph_nxt = col_wrap ? '0 : col_ph_r + PH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_ph_r <= '0;
      row_ph_r <= '0;
    end else begin
      col_ph_r <= col_ph_nxt;
      row_ph_r <= row_ph_nxt;
    end
  end

endmodule

@@ rtl/core/spod_back.sv @@
// Back end: rank memory, clear and spiral build sequencer, threshold pipeline.
module spod_back #(
  parameter int unsigned MAX_SIZE = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic [$clog2(MAX_SIZE+1)-1:0]             n,
  input  logic [$clog2(MAX_SIZE*MAX_SIZE+2)-1:0]    nsq,
  output logic                                      init_busy,
  input  logic                                      q_valid,
  output logic                                      q_ready,
  input  logic [2*$clog2(MAX_SIZE)+8:0]             q_data,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output spod_pkg::color_t                          out_level
);

  import spod_pkg::*;

  localparam int unsigned PH_W  = $clog2(MAX_SIZE);
  localparam int unsigned N_W   = $clog2(MAX_SIZE + 1);
  localparam int unsigned RK_W  = $clog2(MAX_SIZE * MAX_SIZE + 2);
  localparam int unsigned AW    = 2 * PH_W;
  localparam int unsigned RUN_W = $clog2(2 * MAX_SIZE);
  localparam int unsigned PW    = COLOR_W + RK_W;
  localparam int unsigned QW    = 2 * PH_W + COLOR_W + 1;

  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef enum logic [1:0] {ST_CLEAR, ST_START, ST_WALK, ST_RUN} state_t;

  state_t           state_r;
  logic             bld_r;
  logic [AW-1:0]    clr_addr_r;
  logic [PH_W-1:0]  r_r;
  logic [PH_W-1:0]  c_r;
  logic [RUN_W-1:0] run_r;
  logic [PH_W-1:0]  k_r;
  logic [RK_W-1:0]  odd_r;
  logic [RK_W-1:0]  even_r;
  logic [RK_W-1:0]  odd_lim_r;
  logic [RK_W-1:0]  even_lim_r;

  logic             s1_v_r;
  logic             s2_v_r;
  logic             out_valid_r;
  color_t           s1_gray_r;
  logic [RK_W-1:0]  rd_data_r;
  logic [RK_W-1:0]  s2_rank_r;
  logic [PW-1:0]    prod_r;
  color_t           out_level_r;

  logic [RK_W-1:0]  mem [2**AW];

  logic             hd_kind;
  color_t           hd_gray;
  logic [AW-1:0]    rd_addr;
  logic             adv;
  logic             pop;
  logic             pop_pix;
  logic [RK_W-1:0]  nsq1;

  logic [1:0]       dir;
  logic [N_W:0]     n_x;
  logic             on_grid;
  logic [PH_W-1:0]  nr;
  logic [PH_W-1:0]  nc;
  logic             odd_ok;
  logic             even_ok;
  logic [RK_W-1:0]  odd_plus;
  logic [RK_W-1:0]  even_plus;
  logic [RK_W-1:0]  rank_new;
  logic             take;
  logic             k_last;
  logic             run_last;
  logic [PH_W-1:0]  mid;
  logic [PH_W-1:0]  r0;

  logic             we;
  logic [AW-1:0]    wa;
  logic [RK_W-1:0]  wd;

  assign hd_kind = q_data[QW-1];
  assign hd_gray = q_data[QW-2 -: COLOR_W];
  assign rd_addr = q_data[AW-1:0];

  assign adv       = !out_valid_r || out_ready;
  assign q_ready   = (state_r == ST_RUN) && ((hd_kind == KIND_BUILD) || adv);
  assign pop       = q_valid && q_ready;
  assign pop_pix   = pop && (hd_kind != KIND_BUILD);
  assign init_busy = (state_r == ST_CLEAR) && !bld_r;
  assign nsq1      = nsq + RK_W'(1);

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

  // spiral walk step
  always_comb begin
    dir     = run_r[1:0];
    n_x     = (N_W+1)'(n);
    on_grid = 1'b0;
    nr      = r_r;
    nc      = c_r;
    case (dir)
      DIR_DOWN: begin
        on_grid = ((N_W+1)'(r_r) + (N_W+1)'(1)) < n_x;
        nr      = r_r + PH_W'(1);
      end
      DIR_LEFT: begin
        on_grid = (c_r != '0);
        nc      = c_r - PH_W'(1);
      end
      DIR_UP: begin
        on_grid = (r_r != '0);
        nr      = r_r - PH_W'(1);
      end
      default: begin
        on_grid = ((N_W+1)'(c_r) + (N_W+1)'(1)) < n_x;
        nc      = c_r + PH_W'(1);
      end
    endcase
    odd_ok    = odd_r < odd_lim_r;
    even_ok   = even_r < even_lim_r;
    odd_plus  = odd_r + RK_W'(2);
    even_plus = even_r + RK_W'(2);
    rank_new  = odd_ok ? odd_plus : even_plus;
    take      = on_grid && (odd_ok || even_ok);
    k_last    = (RUN_W'(k_r) == (run_r >> 1));
    run_last  = ((RUN_W+1)'(run_r)) == (((RUN_W+1)'(n) << 1) - (RUN_W+1)'(2));
    mid       = PH_W'(n >> 1);
    r0        = n[0] ? mid : mid - PH_W'(1);
  end

  always_comb begin
    we = 1'b0;
    wa = clr_addr_r;
    wd = '0;
    unique case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_START: begin
        we = 1'b1;
        wa = {r0, mid};
        wd = RK_W'(1);
      end
      ST_WALK: begin
        we = take;
        wa = {nr, nc};
        wd = rank_new;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      bld_r       <= 1'b0;
      clr_addr_r  <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (&clr_addr_r) begin
            state_r <= bld_r ? ST_START : ST_RUN;
          end
        end
        ST_START: begin
          r_r        <= r0;
          c_r        <= mid;
          odd_r      <= RK_W'(1);
          even_r     <= '0;
          odd_lim_r  <= n[0] ? nsq : nsq - RK_W'(1);
          even_lim_r <= n[0] ? nsq - RK_W'(1) : nsq;
          run_r      <= '0;
          k_r        <= '0;
          state_r    <= ST_WALK;
        end
        ST_WALK: begin
          if (take) begin
            r_r <= nr;
            c_r <= nc;
            if (odd_ok) begin
              odd_r <= odd_plus;
            end else begin
              even_r <= even_plus;
            end
          end
          if (k_last) begin
            k_r   <= '0;
            run_r <= run_r + RUN_W'(1);
            if (run_last) begin
              state_r <= ST_RUN;
              bld_r   <= 1'b0;
            end
          end else begin
            k_r <= k_r + PH_W'(1);
          end
        end
        ST_RUN: begin
          if (pop && (hd_kind == KIND_BUILD)) begin
            state_r <= ST_CLEAR;
            bld_r   <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
      if (adv) begin
        s1_v_r      <= pop_pix;
        s2_v_r      <= s1_v_r;
        out_valid_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data_r   <= mem[rd_addr];
      s1_gray_r   <= hd_gray;
      prod_r      <= PW'(s1_gray_r) * PW'(nsq1);
      s2_rank_r   <= rd_data_r;
      out_level_r <= (prod_r > (PW'(s2_rank_r) << RANK_SHIFT)) ? LEVEL_WHITE : LEVEL_BLACK;
    end
  end

endmodule

@@ rtl/core/spod_checker.sv @@
// Port-level checker for the spiral ordered dither block, with its bind.
module spod_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input spod_pkg::color_t out_level
);

  import spod_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level))
    else $error("result transaction changed while stalled");

  a_out_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level == LEVEL_WHITE || out_level == LEVEL_BLACK))
    else $error("level is neither white nor black");

  a_rst_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during post-reset memory clear");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind spiral_ordered_dither spod_checker u_spod_checker (.*);
